// File: rtl/cawf_pkg.sv
// Shared operation codes and flag type for the CPU ALU with flags.
`default_nettype none

package cawf_pkg;

   localparam int CMD_W = 5;

   localparam logic [CMD_W-1:0] CMD_ADD    = 5'd0;
   localparam logic [CMD_W-1:0] CMD_ADC    = 5'd1;
   localparam logic [CMD_W-1:0] CMD_SUB    = 5'd2;
   localparam logic [CMD_W-1:0] CMD_SBC    = 5'd3;
   localparam logic [CMD_W-1:0] CMD_AND    = 5'd4;
   localparam logic [CMD_W-1:0] CMD_XOR    = 5'd5;
   localparam logic [CMD_W-1:0] CMD_OR     = 5'd6;
   localparam logic [CMD_W-1:0] CMD_CP     = 5'd7;
   localparam logic [CMD_W-1:0] CMD_INC    = 5'd8;
   localparam logic [CMD_W-1:0] CMD_DEC    = 5'd9;
   localparam logic [CMD_W-1:0] CMD_DAA    = 5'd10;
   localparam logic [CMD_W-1:0] CMD_CPL    = 5'd11;
   localparam logic [CMD_W-1:0] CMD_CCF    = 5'd12;
   localparam logic [CMD_W-1:0] CMD_SCF    = 5'd13;
   localparam logic [CMD_W-1:0] CMD_RLC    = 5'd14;
   localparam logic [CMD_W-1:0] CMD_RL     = 5'd15;
   localparam logic [CMD_W-1:0] CMD_RRC    = 5'd16;
   localparam logic [CMD_W-1:0] CMD_RR     = 5'd17;
   localparam logic [CMD_W-1:0] CMD_SLA    = 5'd18;
   localparam logic [CMD_W-1:0] CMD_SRA    = 5'd19;
   localparam logic [CMD_W-1:0] CMD_SRL    = 5'd20;
   localparam logic [CMD_W-1:0] CMD_SWAP   = 5'd21;
   localparam logic [CMD_W-1:0] CMD_BIT    = 5'd22;
   localparam logic [CMD_W-1:0] CMD_RES    = 5'd23;
   localparam logic [CMD_W-1:0] CMD_SET    = 5'd24;
   localparam logic [CMD_W-1:0] CMD_ADD16  = 5'd25;
   localparam logic [CMD_W-1:0] CMD_ADDSP  = 5'd26;
   localparam logic [CMD_W-1:0] CMD_INC16  = 5'd27;
   localparam logic [CMD_W-1:0] CMD_DEC16  = 5'd28;

   localparam logic [7:0] DAA_HI_ADJ = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ = 8'h06;
   localparam logic [7:0] DAA_HI_MAX = 8'h99;
   localparam logic [3:0] DAA_LO_MAX = 4'h9;

   // Bit order matches the flag word: Z in bit 3 down to C in bit 0.
   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

endpackage

`default_nettype wire

// File: rtl/cawf_alu.sv
// Combinational datapath that computes one ALU result and its flags.
`default_nettype none

module cawf_alu (
   input  wire logic [cawf_pkg::CMD_W-1:0] command,
   input  wire logic [15:0]                operand_a,
   input  wire logic [15:0]                operand_b,
   input  wire logic [2:0]                 bit_index,
   input  wire logic                       prefixed_form,
   input  wire cawf_pkg::flags_type        flags_in,
   output      logic [15:0]                result_value,
   output      cawf_pkg::flags_type        flags_out
);
   import cawf_pkg::*;

   logic [7:0]  a;
   logic [7:0]  b;
   logic        add_carry;
   logic        sub_carry;
   logic [8:0]  sum9;
   logic [4:0]  hsum5;
   logic [8:0]  diff9;
   logic [4:0]  hdiff5;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic        daa_hi;
   logic        daa_lo;
   logic [7:0]  daa_add;
   logic [7:0]  daa_sub;
   logic [7:0]  daa_r;
   logic        daa_c;
   logic [7:0]  rot_r;
   logic        rot_c;
   logic [7:0]  bit_mask;
   logic [16:0] sum17;
   logic [12:0] hsum13;
   logic [15:0] sp_sum;
   logic [7:0]  r8;
   logic        r8_zero;

   assign a = operand_a[7:0];
   assign b = operand_b[7:0];

   assign add_carry = (command == CMD_ADC) ? flags_in.c : 1'b0;
   assign sub_carry = (command == CMD_SBC) ? flags_in.c : 1'b0;

   assign sum9   = {1'b0, a} + {1'b0, b} + {8'b0, add_carry};
   assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, add_carry};
   // The top bit of the widened difference is the borrow out.
   assign diff9  = {1'b0, a} - {1'b0, b} - {8'b0, sub_carry};
   assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, sub_carry};

   assign inc8 = a + 8'd1;
   assign dec8 = a - 8'd1;

   // Adding the upper correction leaves the low nibble alone, so both
   // checks can look at the original accumulator.
   assign daa_hi  = flags_in.c || (a > DAA_HI_MAX);
   assign daa_lo  = flags_in.h || (a[3:0] > DAA_LO_MAX);
   assign daa_add = (daa_hi ? DAA_HI_ADJ : 8'h00) | (daa_lo ? DAA_LO_ADJ : 8'h00);
   assign daa_sub = (flags_in.c ? DAA_HI_ADJ : 8'h00) | (flags_in.h ? DAA_LO_ADJ : 8'h00);
   assign daa_r   = flags_in.n ? (a - daa_sub) : (a + daa_add);
   assign daa_c   = flags_in.n ? flags_in.c : daa_hi;

   always_comb begin
      unique case (command)
         CMD_RLC: begin
            rot_r = {a[6:0], a[7]};
            rot_c = a[7];
         end
         CMD_RL: begin
            rot_r = {a[6:0], flags_in.c};
            rot_c = a[7];
         end
         CMD_RRC: begin
            rot_r = {a[0], a[7:1]};
            rot_c = a[0];
         end
         default: begin
            rot_r = {flags_in.c, a[7:1]};
            rot_c = a[0];
         end
      endcase
   end

   assign bit_mask = 8'd1 << bit_index;

   assign sum17  = {1'b0, operand_a} + {1'b0, operand_b};
   assign hsum13 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
   assign sp_sum = operand_a + {{8{b[7]}}, b};

   always_comb begin
      r8           = a;
      result_value = 16'h0000;
      flags_out    = flags_in;
      unique case (command)
         CMD_ADD, CMD_ADC: begin
            r8          = sum9[7:0];
            flags_out.n = 1'b0;
            flags_out.h = hsum5[4];
            flags_out.c = sum9[8];
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            r8          = (command == CMD_CP) ? a : diff9[7:0];
            flags_out.n = 1'b1;
            flags_out.h = hdiff5[4];
            flags_out.c = diff9[8];
         end
         CMD_AND: begin
            r8          = a & b;
            flags_out.n = 1'b0;
            flags_out.h = 1'b1;
            flags_out.c = 1'b0;
         end
         CMD_XOR: begin
            r8          = a ^ b;
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = 1'b0;
         end
         CMD_OR: begin
            r8          = a | b;
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = 1'b0;
         end
         CMD_INC: begin
            r8          = inc8;
            flags_out.n = 1'b0;
            flags_out.h = (a[3:0] == 4'hF);
         end
         CMD_DEC: begin
            r8          = dec8;
            flags_out.n = 1'b1;
            flags_out.h = (a[3:0] == 4'h0);
         end
         CMD_DAA: begin
            r8          = daa_r;
            flags_out.h = 1'b0;
            flags_out.c = daa_c;
         end
         CMD_CPL: begin
            r8          = ~a;
            flags_out.n = 1'b1;
            flags_out.h = 1'b1;
         end
         CMD_CCF: begin
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = ~flags_in.c;
         end
         CMD_SCF: begin
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = 1'b1;
         end
         CMD_RLC, CMD_RL, CMD_RRC, CMD_RR: begin
            r8          = rot_r;
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = rot_c;
         end
         CMD_SLA: begin
            r8          = {a[6:0], 1'b0};
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = a[7];
         end
         CMD_SRA: begin
            r8          = {a[7], a[7:1]};
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = a[0];
         end
         CMD_SRL: begin
            r8          = {1'b0, a[7:1]};
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = a[0];
         end
         CMD_SWAP: begin
            r8          = {a[3:0], a[7:4]};
            flags_out.n = 1'b0;
            flags_out.h = 1'b0;
            flags_out.c = 1'b0;
         end
         CMD_BIT: begin
            flags_out.z = ~a[bit_index];
            flags_out.n = 1'b0;
            flags_out.h = 1'b1;
         end
         CMD_RES: r8 = a & ~bit_mask;
         CMD_SET: r8 = a | bit_mask;
         CMD_ADD16, CMD_ADDSP, CMD_INC16, CMD_DEC16: r8 = a;
         default: r8 = a;
      endcase

      r8_zero = (r8 == 8'h00);

      // Zero flag for the byte results that derive it from the value.
      unique case (command)
         CMD_ADD, CMD_ADC, CMD_AND, CMD_XOR, CMD_OR, CMD_INC, CMD_DEC,
         CMD_DAA, CMD_SLA, CMD_SRA, CMD_SRL, CMD_SWAP:
            flags_out.z = r8_zero;
         CMD_SUB, CMD_SBC, CMD_CP:
            flags_out.z = (diff9[7:0] == 8'h00);
         CMD_RLC, CMD_RL, CMD_RRC, CMD_RR:
            flags_out.z = prefixed_form && r8_zero;
         default: ;
      endcase

      unique case (command)
         CMD_ADD16: begin
            result_value = sum17[15:0];
            flags_out.n  = 1'b0;
            flags_out.h  = hsum13[12];
            flags_out.c  = sum17[16];
         end
         CMD_ADDSP: begin
            result_value = sp_sum;
            flags_out.z  = 1'b0;
            flags_out.n  = 1'b0;
            flags_out.h  = hsum5[4];
            flags_out.c  = sum9[8];
         end
         CMD_INC16: result_value = operand_a + 16'd1;
         CMD_DEC16: result_value = operand_a - 16'd1;
         CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBC, CMD_AND, CMD_XOR, CMD_OR, CMD_CP,
         CMD_INC, CMD_DEC, CMD_DAA, CMD_CPL, CMD_CCF, CMD_SCF, CMD_RLC, CMD_RL,
         CMD_RRC, CMD_RR, CMD_SLA, CMD_SRA, CMD_SRL, CMD_SWAP, CMD_BIT, CMD_RES,
         CMD_SET:
            result_value = {8'h00, r8};
         // Codes without an operation return the whole first operand.
         default: result_value = operand_a;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/cpu_alu_with_flags.sv
// Top level of the CPU ALU with flags: input register, datapath, result register.
// An accepted word is held in the input register, then in the result register.
// Throughput: one word per cycle unless rsp_stall holds the result; the input and
// result registers hold one word each, so a stalled result lets one more word enter.
// Reset clears the valid bits of both registers; payload registers are not reset.
`default_nettype none

module cpu_alu_with_flags (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic [cawf_pkg::CMD_W-1:0] req_command,
   input  wire logic [15:0]                req_operand_a,
   input  wire logic [15:0]                req_operand_b,
   input  wire logic [2:0]                 req_bit_index,
   input  wire logic                       req_prefixed_form,
   input  wire logic [3:0]                 req_flags_in,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic [15:0]                rsp_result_value,
   output      logic [3:0]                 rsp_flags_out
);
   import cawf_pkg::*;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [CMD_W-1:0]   s1_command_ff;
   logic [15:0]        s1_operand_a_ff;
   logic [15:0]        s1_operand_b_ff;
   logic [2:0]         s1_bit_index_ff;
   logic               s1_prefixed_ff;
   flags_type          s1_flags_ff;

   logic               out_valid_ff;
   logic               out_valid_in;
   logic [15:0]        out_result_ff;
   flags_type          out_flags_ff;

   logic               out_advance;
   logic               s1_advance;
   logic               req_accept;
   logic [15:0]        alu_result;
   flags_type          alu_flags;

   assign out_advance = !out_valid_ff || !rsp_stall;
   assign s1_advance  = !s1_valid_ff || out_advance;
   assign req_stall   = !s1_advance;
   assign req_accept  = req_valid && s1_advance;

   assign s1_valid_in  = s1_advance ? req_valid : s1_valid_ff;
   assign out_valid_in = out_advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff   <= req_command;
         s1_operand_a_ff <= req_operand_a;
         s1_operand_b_ff <= req_operand_b;
         s1_bit_index_ff <= req_bit_index;
         s1_prefixed_ff  <= req_prefixed_form;
         s1_flags_ff     <= flags_type'(req_flags_in);
      end
   end

   cawf_alu u_alu (
      .command       (s1_command_ff),
      .operand_a     (s1_operand_a_ff),
      .operand_b     (s1_operand_b_ff),
      .bit_index     (s1_bit_index_ff),
      .prefixed_form (s1_prefixed_ff),
      .flags_in      (s1_flags_ff),
      .result_value  (alu_result),
      .flags_out     (alu_flags)
   );

   always_ff @(posedge clock) begin
      if (out_advance && s1_valid_ff) begin
         out_result_ff <= alu_result;
         out_flags_ff  <= alu_flags;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_result_ff;
   assign rsp_flags_out    = out_flags_ff;

endmodule

`default_nettype wire
